// ----- sv/dcrc_pkg.sv -----
// dimmer command and ramp controller: shared types and constants
// no dependencies; used by every module of the block
`default_nettype none

package dcrc_pkg;

  // fixed sizes
  localparam int REPLY_BYTES = 8;
  localparam int UNIT_COUNT  = 16;
  localparam int FRAME_MAX   = 5;
  localparam int IDX_W       = $clog2(REPLY_BYTES);
  localparam int FCNT_W      = 3;

  // item kinds on the input channel
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_ZC   = 2'd2;

  // result kinds
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_GATE  = 1'b1;

  // frame bytes and opcodes
  localparam logic [7:0] BCAST_ID       = 8'h55;
  localparam logic [7:0] ACK_BYTE       = 8'h06;
  localparam logic [7:0] OP_SET_VALUE   = 8'h01;
  localparam logic [7:0] OP_SET_CURRENT = 8'h03;
  localparam logic [7:0] OP_SET_TEMP    = 8'h04;
  localparam logic [7:0] OP_RESET       = 8'h05;
  localparam logic [7:0] OP_GET_STATE   = 8'h06;

  // configuration register indexes
  localparam logic CFG_UNIT_ADDRESS = 1'b0;
  localparam logic CFG_RAMP_PERIOD  = 1'b1;

  localparam logic [7:0] RAMP_PERIOD_RESET = 8'd5;

  // run mode, one-hot
  typedef enum logic [2:0] {
    MODE_INIT = 3'b001,
    MODE_STOP = 3'b010,
    MODE_RUN  = 3'b100
  } mode_t;

  // result handed from the core to the output buffer
  typedef struct packed {
    logic                             load;
    logic                             is_gate;
    logic [REPLY_BYTES-1:0][7:0]      bytes;
    logic [14:0]                      gate_us;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/dcrc_core.sv -----
// dimmer controller core: input register, frame assembly, command
// handling and ramp state; depends on dcrc_pkg
`default_nettype none

module dcrc_core #(
  parameter int UNIT_COUNT = dcrc_pkg::UNIT_COUNT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        cmd,
  input  wire logic [7:0]        rx_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              buf_free,
  output dcrc_pkg::result_t      res
);

  // input register
  logic       q_valid;
  logic [1:0] q_cmd;
  logic [7:0] q_data;

  // configuration
  logic [3:0] unit_address;
  logic [7:0] ramp_period;

  // controller state
  logic [dcrc_pkg::FCNT_W-1:0] frame_count, frame_count_next;
  logic [7:0]                  frame_bytes [dcrc_pkg::FRAME_MAX];
  logic [11:0]                 level_now, level_now_next;
  logic [11:0]                 level_target, level_target_next;
  logic [7:0]                  ms_since_step, ms_since_step_next;
  logic [7:0]                  ramp_setting, ramp_setting_next;
  logic [7:0]                  current_max, current_max_next;
  logic [7:0]                  temp_max, temp_max_next;
  dcrc_pkg::mode_t             run_mode, run_mode_next;

  logic                        produces;
  logic                        proceed;
  logic                        byte_we;
  logic [dcrc_pkg::FCNT_W-1:0] fc;

  assign cfg_ready = 1'b1;
  assign proceed   = q_valid && (!produces || buf_free);
  assign in_stall  = q_valid && !proceed;

  // level / 10 by reciprocal multiply, exact for 12-bit levels up to 2559
  logic [27:0] div_prod;
  logic [7:0]  level_div10;
  assign div_prod    = {16'd0, level_now} * 28'd52429;
  assign level_div10 = div_prod[26:19];

  // run mode as reported in a status reply
  logic [7:0] mode_num;
  always_comb begin
    case (run_mode)
      dcrc_pkg::MODE_STOP: mode_num = 8'd1;
      dcrc_pkg::MODE_RUN:  mode_num = 8'd2;
      default:             mode_num = 8'd0;
    endcase
  end

  // one pass over the held item
  always_comb begin
    logic [7:0]                  fb [dcrc_pkg::FRAME_MAX];
    logic [dcrc_pkg::FCNT_W-1:0] newcount;
    logic [dcrc_pkg::FCNT_W-1:0] need;
    logic                        complete;
    logic [7:0]                  id;
    logic [7:0]                  op;
    logic                        mine;
    logic                        id_ok;
    logic                        reply_ok;
    logic [7:0]                  ms_inc;

    fc = (frame_count >= dcrc_pkg::FCNT_W'(dcrc_pkg::FRAME_MAX)) ? '0 : frame_count;
    for (int i = 0; i < dcrc_pkg::FRAME_MAX; i++) begin
      fb[i] = (fc == dcrc_pkg::FCNT_W'(i)) ? q_data : frame_bytes[i];
    end
    newcount = fc + dcrc_pkg::FCNT_W'(1);
    need     = dcrc_pkg::FCNT_W'(3);
    if (newcount > dcrc_pkg::FCNT_W'(1)) begin
      if (fb[1] == dcrc_pkg::OP_RESET) begin
        need = dcrc_pkg::FCNT_W'(5);
      end else if (fb[1] == dcrc_pkg::OP_GET_STATE) begin
        need = dcrc_pkg::FCNT_W'(2);
      end
    end
    complete = newcount >= need;

    id    = fb[0];
    op    = fb[1];
    mine  = id == {4'd0, unit_address};
    id_ok = (id < 8'(UNIT_COUNT)) || (id == dcrc_pkg::BCAST_ID);
    reply_ok = id_ok && ((op == dcrc_pkg::OP_SET_VALUE) ||
                         (op == dcrc_pkg::OP_SET_CURRENT) ||
                         (op == dcrc_pkg::OP_SET_TEMP) ||
                         (op == dcrc_pkg::OP_RESET) ||
                         (op == dcrc_pkg::OP_GET_STATE));

    ms_inc = (ms_since_step == 8'hFF) ? ms_since_step : ms_since_step + 8'd1;

    frame_count_next   = frame_count;
    level_now_next     = level_now;
    level_target_next  = level_target;
    ms_since_step_next = ms_since_step;
    ramp_setting_next  = ramp_setting;
    current_max_next   = current_max;
    temp_max_next      = temp_max;
    run_mode_next      = run_mode;
    byte_we            = 1'b0;

    res.load    = 1'b0;
    res.is_gate = 1'b0;
    res.bytes   = '0;
    res.gate_us = 15'({level_now, 3'd0}) + 15'({level_now, 1'd0});

    produces = 1'b0;
    case (q_cmd)
      dcrc_pkg::CMD_BYTE: begin
        produces = complete && reply_ok;
        byte_we  = 1'b1;
        frame_count_next = complete ? '0 : newcount;
        if (complete && reply_ok) begin
          case (op)
            dcrc_pkg::OP_SET_VALUE: begin
              if (mine) begin
                level_target_next = {4'd0, fb[2]} * 12'd10;
                res.bytes[0]      = dcrc_pkg::ACK_BYTE;
              end
            end
            dcrc_pkg::OP_SET_CURRENT: begin
              if (mine) begin
                current_max_next = fb[2];
                res.bytes[0]     = dcrc_pkg::ACK_BYTE;
              end
            end
            dcrc_pkg::OP_SET_TEMP: begin
              if (mine) begin
                temp_max_next = fb[2];
                res.bytes[0]  = dcrc_pkg::ACK_BYTE;
              end
            end
            dcrc_pkg::OP_RESET: begin
              level_now_next = '0;
              if (id != dcrc_pkg::BCAST_ID) begin
                ramp_setting_next = fb[2];
                current_max_next  = fb[3];
                temp_max_next     = fb[4];
              end
              run_mode_next = dcrc_pkg::MODE_INIT;
              res.bytes[0]  = dcrc_pkg::ACK_BYTE;
            end
            default: begin
              // status dump; broadcast id gives zeros
              if (id < 8'(UNIT_COUNT)) begin
                res.bytes[0] = id;
                res.bytes[1] = dcrc_pkg::OP_GET_STATE;
                res.bytes[2] = level_div10;
                res.bytes[4] = ramp_setting;
                res.bytes[5] = current_max;
                res.bytes[6] = temp_max;
                res.bytes[7] = mode_num;
              end
            end
          endcase
        end
      end
      dcrc_pkg::CMD_TICK: begin
        ms_since_step_next = ms_inc;
        case (run_mode)
          dcrc_pkg::MODE_STOP: run_mode_next = dcrc_pkg::MODE_RUN;
          dcrc_pkg::MODE_RUN: begin
            if (ms_inc >= ramp_period) begin
              ms_since_step_next = '0;
              if (level_now < level_target) begin
                level_now_next = level_now + 12'd1;
              end else if (level_now > level_target) begin
                level_now_next = level_now - 12'd1;
              end
            end
          end
          default: begin
            level_now_next    = '0;
            level_target_next = '0;
            run_mode_next     = dcrc_pkg::MODE_STOP;
          end
        endcase
      end
      dcrc_pkg::CMD_ZC: begin
        produces    = level_now != '0;
        res.is_gate = 1'b1;
      end
      default: begin
        produces = 1'b0;
      end
    endcase
    res.load = proceed && produces;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      q_valid <= 1'b1;
    end else if (proceed) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_cmd  <= cmd;
      q_data <= rx_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_address <= '0;
      ramp_period  <= dcrc_pkg::RAMP_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == dcrc_pkg::CFG_UNIT_ADDRESS) begin
        unit_address <= cfg_data[3:0];
      end else begin
        ramp_period <= cfg_data;
      end
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= '0;
      level_now     <= '0;
      level_target  <= '0;
      ms_since_step <= '0;
      ramp_setting  <= '0;
      current_max   <= '0;
      temp_max      <= '0;
      run_mode      <= dcrc_pkg::MODE_INIT;
    end else if (proceed) begin
      frame_count   <= frame_count_next;
      level_now     <= level_now_next;
      level_target  <= level_target_next;
      ms_since_step <= ms_since_step_next;
      ramp_setting  <= ramp_setting_next;
      current_max   <= current_max_next;
      temp_max      <= temp_max_next;
      run_mode      <= run_mode_next;
    end
  end

  // frame byte store
  always_ff @(posedge clk) begin
    if (proceed && byte_we) begin
      frame_bytes[fc] <= q_data;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid && produces && !buf_free)
    else $error("input stalled without a blocked item");

  a_frame_count_range: assert property (@(posedge clk) disable iff (rst)
    frame_count < dcrc_pkg::FCNT_W'(dcrc_pkg::FRAME_MAX))
    else $error("frame count out of range");

  a_mode_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(run_mode))
    else $error("run mode is not one-hot");
`endif

endmodule

`default_nettype wire

// ----- sv/dcrc_out.sv -----
// dimmer controller output buffer: holds one reply or gate result and
// sends it one item per cycle while out_stall is low; depends on dcrc_pkg
`default_nettype none

module dcrc_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dcrc_pkg::result_t res,
  output logic                   buf_free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   kind,
  output logic [7:0]             tx_data,
  output logic [14:0]            gate_on_us,
  output logic                   last
);

  logic                                        is_gate;
  logic [dcrc_pkg::REPLY_BYTES-1:0][7:0]       bytes;
  logic [14:0]                                 gate_us;
  logic [dcrc_pkg::IDX_W-1:0]                  idx;

  // output fields
  assign kind       = is_gate ? dcrc_pkg::KIND_GATE : dcrc_pkg::KIND_REPLY;
  assign tx_data    = is_gate ? 8'd0 : bytes[idx];
  assign gate_on_us = is_gate ? gate_us : 15'd0;
  assign last       = is_gate || (idx == dcrc_pkg::IDX_W'(dcrc_pkg::REPLY_BYTES - 1));
  assign buf_free   = !out_valid || (!out_stall && last);

  // valid and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (res.load) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (out_valid && !out_stall) begin
      if (last) begin
        out_valid <= 1'b0;
      end else begin
        idx <= idx + dcrc_pkg::IDX_W'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res.load) begin
      is_gate <= res.is_gate;
      bytes   <= res.bytes;
      gate_us <= res.gate_us;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res.load |-> buf_free)
    else $error("result loaded into a busy buffer");

  a_gate_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_gate) |-> gate_on_us != 15'd0)
    else $error("gate item with zero on-time");

  a_reply_advances: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=>
      (out_valid && idx == $past(idx) + dcrc_pkg::IDX_W'(1)))
    else $error("reply byte index did not advance");
`endif

endmodule

`default_nettype wire

// ----- sv/dimmer_command_ramp_controller.sv -----
// dimmer command and ramp controller top level
// depends on dcrc_pkg, dcrc_core and dcrc_out
`default_nettype none

// Items (serial bytes, millisecond ticks, zero crossings) enter an input
// register and are handled in one pass each. Items that give no result are
// taken every cycle, even while a reply drains. A completed frame with a valid
// id and opcode yields eight reply bytes and a zero crossing at nonzero level
// yields one gate item; these leave a one-entry output buffer at one item per
// cycle while out_stall is low, so an item that produces results waits in the
// input register and stalls the input while the previous reply drains. With the
// buffer free, such an item passes from the input register to the registered
// out_valid. Configuration writes are always ready and belong in a quiet
// period with nothing in flight. UNIT_COUNT bounds the valid bus ids.

module dimmer_command_ramp_controller #(
  parameter int UNIT_COUNT = dcrc_pkg::UNIT_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  rx_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       tx_data,
  output logic [14:0]      gate_on_us,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  dcrc_pkg::result_t res;
  logic              buf_free;

  // command handling and ramp state
  dcrc_core #(
    .UNIT_COUNT (UNIT_COUNT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .rx_data   (rx_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .buf_free  (buf_free),
    .res       (res)
  );

  // result buffer and serializer
  dcrc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .buf_free   (buf_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .tx_data    (tx_data),
    .gate_on_us (gate_on_us),
    .last       (last)
  );

endmodule

`default_nettype wire
